[hw/rtl/tiq2d_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tiq2d_pkg;

    localparam int MAX_NODES_DEF      = 8;
    localparam int MAX_PLOT_NODES_DEF = 8;

    localparam int IDX_W     = 3;
    localparam int CNT_W     = 4;
    localparam int SCOUNT_W  = 7;
    localparam int FLAT_W    = 7;
    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int PART_W    = 24;
    localparam int OUT_W     = 18;
    localparam int PROD_W    = COEF_W + PART_W;
    localparam int FRAC_BITS = 14;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic REQ_COEF   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic REG_NQ      = 1'b0;
    localparam logic REG_PLOT_NQ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN_R,
        ST_DRAIN,
        ST_RUN_S,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic                       req_type;
        logic [IDX_W-1:0]           coef_row;
        logic [IDX_W-1:0]           coef_col;
        logic signed [COEF_W-1:0]   coef_value;
        logic signed [SAMPLE_W-1:0] sample_value;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_value;
        logic [IDX_W-1:0]        out_col;
        logic [IDX_W-1:0]        out_row;
        logic                    out_last;
    } out_item_t;

    // tags that ride along with each multiply-accumulate
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last;
        logic             pass_s;
        logic             final_res;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] i;
    } tag_t;

    typedef struct packed {
        logic prod_en;
        logic acc_en;
        logic acc_first;
    } mac_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/tensor_interp_quad_2d.sv]
// Coefficient items and non-final samples are taken back to back while the block is idle.
// Element (final sample to last result): one multiply-accumulate per cycle on one shared MAC
//   while the output does not stall, Nq*P*(Nq+P) of them in all, P = plot nodes.
// No new items are taken while an element is processed; output stall freezes the MAC pipeline.
// Reset: sample count cleared, node counts set to 8; coefficient, sample and partial
//   memories hold no reset value and must be written before they are read.
`timescale 1ns / 1ps
`default_nettype none

module tensor_interp_quad_2d
    import tiq2d_pkg::*;
#(
    parameter int MAX_NODES      = MAX_NODES_DEF,
    parameter int MAX_PLOT_NODES = MAX_PLOT_NODES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire in_item_t          item,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output out_item_t              res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam int CDEPTH  = MAX_PLOT_NODES * MAX_NODES;
    localparam int SDEPTH  = MAX_NODES * MAX_NODES;
    localparam int PDEPTH  = MAX_NODES * MAX_PLOT_NODES;
    localparam int CADDR_W = $clog2(CDEPTH);
    localparam int SADDR_W = $clog2(SDEPTH);
    localparam int PADDR_W = $clog2(PDEPTH);
    localparam int ACC_W   = PROD_W + $clog2(MAX_NODES);

    // configuration
    logic [CNT_W-1:0] nq_reg;
    logic [CNT_W-1:0] plot_nq_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nq_reg      <= CNT_W'(8);
            plot_nq_reg <= CNT_W'(8);
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_NQ)
            begin
                nq_reg <= pwdata[CNT_W-1:0];
            end
            else
            begin
                plot_nq_reg <= pwdata[CNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_PLOT_NQ)
        begin
            prdata = {{(APB_DW-CNT_W){1'b0}}, plot_nq_reg};
        end
        else
        begin
            prdata = {{(APB_DW-CNT_W){1'b0}}, nq_reg};
        end
    end

    // clamp node counts into their legal ranges
    logic [CNT_W-1:0]    nq_eff;
    logic [CNT_W-1:0]    pq_eff;
    logic [IDX_W-1:0]    nq_m1;
    logic [IDX_W-1:0]    pq_m1;
    logic [SCOUNT_W-1:0] total;

    always_comb
    begin
        if (nq_reg < CNT_W'(2))
        begin
            nq_eff = CNT_W'(2);
        end
        else if (nq_reg > CNT_W'(MAX_NODES))
        begin
            nq_eff = CNT_W'(MAX_NODES);
        end
        else
        begin
            nq_eff = nq_reg;
        end
        if (plot_nq_reg < CNT_W'(1))
        begin
            pq_eff = CNT_W'(1);
        end
        else if (plot_nq_reg > CNT_W'(MAX_PLOT_NODES))
        begin
            pq_eff = CNT_W'(MAX_PLOT_NODES);
        end
        else
        begin
            pq_eff = plot_nq_reg;
        end
        nq_m1 = IDX_W'(nq_eff - CNT_W'(1));
        pq_m1 = IDX_W'(pq_eff - CNT_W'(1));
        total = SCOUNT_W'(nq_eff) * SCOUNT_W'(nq_eff);
    end

    // sequencer
    state_t              state_reg;
    state_t              state_next;
    logic [SCOUNT_W-1:0] count_reg;
    logic [SCOUNT_W-1:0] count_next;
    logic [SCOUNT_W-1:0] count_base;
    logic [IDX_W-1:0]    j_reg;
    logic [IDX_W-1:0]    i_reg;
    logic [IDX_W-1:0]    m_reg;
    logic [IDX_W-1:0]    j_last;
    logic                item_acc;
    logic                coef_acc;
    logic                sample_acc;
    logic                coef_in_range;
    logic                elem_done;
    logic                adv;
    logic                issue;
    logic                issue_fire;
    logic                pass_s;
    logic                m_wrap;
    logic                i_wrap;
    logic                pass_end;
    logic                pipe_empty;
    tag_t                tag_b_reg;
    tag_t                tag_c_reg;
    tag_t                tag_d_reg;
    tag_t                tag_a;

    assign item_acc      = item_valid & ~item_stall;
    assign coef_in_range = (int'(item.coef_row) < MAX_PLOT_NODES)
                         && (int'(item.coef_col) < MAX_NODES);
    assign coef_acc      = item_acc && (item.req_type == REQ_COEF) && coef_in_range;
    assign sample_acc    = item_acc && (item.req_type == REQ_SAMPLE);
    assign count_base    = (count_reg >= total) ? '0 : count_reg;
    assign elem_done     = (count_base + SCOUNT_W'(1)) == total;
    assign count_next    = elem_done ? '0 : count_base + SCOUNT_W'(1);

    assign adv        = ~(res_valid & res_stall);
    assign pipe_empty = ~tag_b_reg.valid & ~tag_c_reg.valid & ~tag_d_reg.valid;
    assign issue_fire = issue & adv;
    assign j_last     = pass_s ? pq_m1 : nq_m1;
    assign m_wrap     = (m_reg == nq_m1);
    assign i_wrap     = m_wrap && (i_reg == pq_m1);
    assign pass_end   = i_wrap && (j_reg == j_last);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_acc && elem_done)
                begin
                    state_next = ST_RUN_R;
                end
            end
            ST_RUN_R:
            begin
                if (issue_fire && pass_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = ST_RUN_S;
                end
            end
            ST_RUN_S:
            begin
                if (issue_fire && pass_end)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (pipe_empty)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall = 1'b1;
        issue      = 1'b0;
        pass_s     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
            end
            ST_RUN_R:
            begin
                issue = 1'b1;
            end
            ST_DRAIN:
            begin
                pass_s = 1'b1;
            end
            ST_RUN_S:
            begin
                issue  = 1'b1;
                pass_s = 1'b1;
            end
            ST_FLUSH:
            begin
                pass_s = 1'b1;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            j_reg     <= '0;
            i_reg     <= '0;
            m_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (sample_acc)
            begin
                count_reg <= count_next;
            end
            // walk j, i, m with m innermost; wrap to zero at the end of a pass
            if (issue_fire)
            begin
                m_reg <= m_wrap ? '0 : m_reg + IDX_W'(1);
                if (m_wrap)
                begin
                    i_reg <= (i_reg == pq_m1) ? '0 : i_reg + IDX_W'(1);
                end
                if (i_wrap)
                begin
                    j_reg <= (j_reg == j_last) ? '0 : j_reg + IDX_W'(1);
                end
            end
        end
    end

    // tag for the operation issued this cycle
    always_comb
    begin
        tag_a.valid     = issue;
        tag_a.first     = (m_reg == '0);
        tag_a.last      = m_wrap;
        tag_a.pass_s    = pass_s;
        tag_a.final_res = pass_s && (i_reg == pq_m1) && (j_reg == pq_m1);
        tag_a.j         = j_reg;
        tag_a.i         = i_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_b_reg <= '0;
            tag_c_reg <= '0;
            tag_d_reg <= '0;
        end
        else if (adv)
        begin
            tag_b_reg <= tag_a;
            tag_c_reg <= tag_b_reg;
            tag_d_reg <= tag_c_reg;
        end
    end

    // memory addressing
    logic [FLAT_W-1:0]        c_waddr_full;
    logic [FLAT_W-1:0]        c_raddr_full;
    logic [FLAT_W-1:0]        s_raddr_full;
    logic [FLAT_W-1:0]        p_waddr_full;
    logic [FLAT_W-1:0]        p_raddr_full;
    logic [IDX_W-1:0]         coef_sel;
    logic [COEF_W-1:0]        c_rdata;
    logic [SAMPLE_W-1:0]      s_rdata;
    logic [PART_W-1:0]        p_rdata;
    logic signed [PART_W-1:0] operand;
    logic signed [PART_W-1:0] sum24;
    logic signed [OUT_W-1:0]  sum18;
    logic                     res_done;
    logic                     p_we;
    mac_ctl_t                 mac_ctl;

    assign coef_sel     = pass_s ? j_reg : i_reg;
    assign c_waddr_full = FLAT_W'(item.coef_row) * FLAT_W'(MAX_NODES)
                        + FLAT_W'(item.coef_col);
    assign c_raddr_full = FLAT_W'(coef_sel) * FLAT_W'(MAX_NODES) + FLAT_W'(m_reg);
    assign s_raddr_full = FLAT_W'(j_reg) * FLAT_W'(nq_eff) + FLAT_W'(m_reg);
    assign p_raddr_full = FLAT_W'(m_reg) * FLAT_W'(MAX_PLOT_NODES) + FLAT_W'(i_reg);
    assign p_waddr_full = FLAT_W'(tag_d_reg.j) * FLAT_W'(MAX_PLOT_NODES)
                        + FLAT_W'(tag_d_reg.i);

    assign res_done = adv & tag_d_reg.valid & tag_d_reg.last;
    assign p_we     = res_done & ~tag_d_reg.pass_s;

    tiq2d_ram #(
        .WIDTH (COEF_W),
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_acc),
        .waddr (c_waddr_full[CADDR_W-1:0]),
        .wdata (item.coef_value),
        .re    (issue_fire),
        .raddr (c_raddr_full[CADDR_W-1:0]),
        .rdata (c_rdata)
    );

    tiq2d_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (SDEPTH)
    ) u_sample_ram (
        .clk   (clk),
        .we    (sample_acc),
        .waddr (count_base[SADDR_W-1:0]),
        .wdata (item.sample_value),
        .re    (issue_fire & ~pass_s),
        .raddr (s_raddr_full[SADDR_W-1:0]),
        .rdata (s_rdata)
    );

    tiq2d_ram #(
        .WIDTH (PART_W),
        .DEPTH (PDEPTH)
    ) u_partial_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr_full[PADDR_W-1:0]),
        .wdata (sum24),
        .re    (issue_fire & pass_s),
        .raddr (p_raddr_full[PADDR_W-1:0]),
        .rdata (p_rdata)
    );

    assign operand = tag_b_reg.pass_s ? p_rdata
                                      : {{(PART_W-SAMPLE_W){s_rdata[SAMPLE_W-1]}}, s_rdata};

    always_comb
    begin
        mac_ctl.prod_en   = adv & tag_b_reg.valid;
        mac_ctl.acc_en    = adv & tag_c_reg.valid;
        mac_ctl.acc_first = tag_c_reg.first;
    end

    tiq2d_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk     (clk),
        .ctl     (mac_ctl),
        .coef    (c_rdata),
        .operand (operand),
        .sum24   (sum24),
        .sum18   (sum18)
    );

    // output register
    logic      res_valid_reg;
    logic      res_valid_next;
    out_item_t res_reg;

    always_comb
    begin
        if (res_done && tag_d_reg.pass_s)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_done && tag_d_reg.pass_s)
        begin
            res_reg.out_value <= sum18;
            res_reg.out_col   <= tag_d_reg.i;
            res_reg.out_row   <= tag_d_reg.j;
            res_reg.out_last  <= tag_d_reg.final_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

[hw/rtl/tiq2d_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tiq2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/tiq2d_mac.sv]
`timescale 1ns / 1ps
`default_nettype none

module tiq2d_mac
    import tiq2d_pkg::*;
#(
    parameter int ACC_W = PROD_W + 3
) (
    input  wire logic                     clk,
    input  wire mac_ctl_t                 ctl,
    input  wire logic signed [COEF_W-1:0] coef,
    input  wire logic signed [PART_W-1:0] operand,
    output logic signed [PART_W-1:0]      sum24,
    output logic signed [OUT_W-1:0]       sum18
);

    localparam int Q_W = ACC_W - FRAC_BITS;
    localparam logic [ACC_W-1:0] HALF =
        {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic [ACC_W-1:0]         rnd_sum;
    logic [Q_W-1:0]           q;
    logic                     fit24;
    logic                     fit18;

    always_comb
    begin
        if (ctl.acc_first)
        begin
            acc_next = ACC_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.prod_en)
        begin
            prod_reg <= coef * operand;
        end
        if (ctl.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    // round half up, then clamp when the upper bits are not pure sign
    always_comb
    begin
        rnd_sum = acc_reg + HALF;
        q       = rnd_sum[ACC_W-1:FRAC_BITS];
        fit24   = (&q[Q_W-1:PART_W-1]) | ~(|q[Q_W-1:PART_W-1]);
        fit18   = (&q[Q_W-1:OUT_W-1]) | ~(|q[Q_W-1:OUT_W-1]);
        if (fit24)
        begin
            sum24 = q[PART_W-1:0];
        end
        else
        begin
            sum24 = {q[Q_W-1], {(PART_W-1){~q[Q_W-1]}}};
        end
        if (fit18)
        begin
            sum18 = q[OUT_W-1:0];
        end
        else
        begin
            sum18 = {q[Q_W-1], {(OUT_W-1){~q[Q_W-1]}}};
        end
    end

endmodule

`default_nettype wire
